[src/key_short_long_press_detector_unit_defines.svh]
// assertion macros shared by the key press detector rtl
// no dependencies; included by modules that carry assertions
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH

// concurrent check on rising clock, off while reset is low
`define KSLPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define KSLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[src/kslpd_pkg.sv]
// shared types, constants and codes for the key press detector
// no dependencies
`timescale 1ns / 1ps

package kslpd_pkg;

  localparam int NumKeys      = 4;
  localparam int MaxHoldCount = 1000;
  localparam int KeySlots     = 4;
  localparam int CountW       = 16;
  localparam int KeyW         = 2;
  localparam int StatusW      = 2;
  localparam int EventW       = 2;
  localparam int CfgDataW     = 64;
  localparam int CfgAddrW     = 5;
  localparam int FifoDepth    = 2;
  localparam int FifoPtrW     = $clog2(FifoDepth);
  localparam int FifoCntW     = $clog2(FifoDepth + 1);
  localparam int DivCntW      = $clog2(CountW);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // status codes of an input item
  localparam logic [StatusW-1:0] StReleased = 2'd0;
  localparam logic [StatusW-1:0] StPressed  = 2'd1;

  // register indexes (paddr[4:3])
  localparam logic [1:0] RegKeyEnable  = 2'd0;
  localparam logic [1:0] RegShortTicks = 2'd1;
  localparam logic [1:0] RegLongTicks  = 2'd2;

  typedef enum logic [EventW-1:0] {
    EvNone  = 2'd0,
    EvShort = 2'd1,
    EvLong  = 2'd2
  } press_event_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkOut
  } back_state_e;

  typedef struct packed {
    logic [KeySlots-1:0]          key_enable;
    logic [KeySlots-1:0]          clear_mask;
    logic [KeySlots*CountW-1:0]   short_tbl;
    logic [KeySlots*CountW-1:0]   long_tbl;
  } cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic              gate;
    logic [CountW-1:0] count;
    logic [CountW-1:0] short_th;
    logic [CountW-1:0] long_th;
  } job_t;

endpackage

[src/kslpd_if.sv]
// valid/ready channel interfaces for key samples and press events
// depends on kslpd_pkg
`timescale 1ns / 1ps

interface kslpd_key_if;
  logic                             valid;
  logic                             ready;
  logic [kslpd_pkg::KeyW-1:0]       key_index;
  logic [kslpd_pkg::StatusW-1:0]    key_state;

  modport source (output valid, output key_index, output key_state, input ready);
  modport sink   (input valid, input key_index, input key_state, output ready);
endinterface

interface kslpd_event_if;
  logic                             valid;
  logic                             ready;
  logic [kslpd_pkg::KeyW-1:0]       key_index_out;
  logic [kslpd_pkg::EventW-1:0]     press_event;

  modport source (output valid, output key_index_out, output press_event, input ready);
  modport sink   (input valid, input key_index_out, input press_event, output ready);
endinterface

[src/key_short_long_press_detector_unit.sv]
// top level: apb config registers, front classifier, job queue, back modulo unit
// depends on kslpd_pkg, kslpd_if, kslpd_front, kslpd_fifo, kslpd_back
//
//   channel   dir   handshake      payload
//   key_i     in    valid/ready    key_index[1:0], key_state[1:0]
//   event_o   out   valid/ready    key_index_out[1:0], press_event[1:0]
//   apb       in    psel/penable   regs at 0x00 enable, 0x08 short, 0x10 long
//
// front takes a sample whenever the two-entry queue has room
// back takes a job when idle and moves to its out state, first running the
// 16-step serial modulo (one quotient bit per cycle) on a long repeat check
// a waiting result stalls the back part; the front fills the queue, then drops ready
// reset clears registers, hold counts and held flags at once
`timescale 1ns / 1ps

module key_short_long_press_detector_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kslpd_key_if.sink                         key_i,
  kslpd_event_if.source                     event_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kslpd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [kslpd_pkg::CfgDataW-1:0]    pwdata,
  output logic [kslpd_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready
);

  localparam int TblW = kslpd_pkg::KeySlots * kslpd_pkg::CountW;

  logic [kslpd_pkg::KeySlots-1:0] enable_q;
  logic [TblW-1:0]                short_q, long_q;
  logic                           wr_en;
  logic [1:0]                     reg_idx;
  kslpd_pkg::cfg_t                cfg;
  kslpd_pkg::job_t                push_job, pop_job;
  logic                           push, pop, full, job_valid;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      short_q  <= '0;
      long_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        kslpd_pkg::RegKeyEnable:  enable_q <= pwdata[kslpd_pkg::KeySlots-1:0];
        kslpd_pkg::RegShortTicks: short_q  <= pwdata[TblW-1:0];
        kslpd_pkg::RegLongTicks:  long_q   <= pwdata[TblW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kslpd_pkg::RegKeyEnable:  prdata = kslpd_pkg::CfgDataW'(enable_q);
      kslpd_pkg::RegShortTicks: prdata = kslpd_pkg::CfgDataW'(short_q);
      kslpd_pkg::RegLongTicks:  prdata = kslpd_pkg::CfgDataW'(long_q);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    cfg.key_enable = enable_q;
    cfg.short_tbl  = short_q;
    cfg.long_tbl   = long_q;
    // keys whose enable bit flips on this write
    cfg.clear_mask = (wr_en && reg_idx == kslpd_pkg::RegKeyEnable)
                   ? (pwdata[kslpd_pkg::KeySlots-1:0] ^ enable_q) : '0;
  end

  kslpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (key_i.valid),
    .in_ready_o   (key_i.ready),
    .key_index_i  (key_i.key_index),
    .key_state_i  (key_i.key_state),
    .push_o       (push),
    .full_i       (full),
    .job_o        (push_job)
  );

  kslpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  kslpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (event_o.valid),
    .out_ready_i   (event_o.ready),
    .key_index_o   (event_o.key_index_out),
    .press_event_o (event_o.press_event)
  );

endmodule

[src/kslpd_front.sv]
// front part: accepts key samples, updates per-key hold state, emits jobs
// depends on kslpd_pkg
`timescale 1ns / 1ps

module kslpd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kslpd_pkg::cfg_t       cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [kslpd_pkg::KeyW-1:0]    key_index_i,
  input  logic [kslpd_pkg::StatusW-1:0] key_state_i,
  output logic                  push_o,
  input  logic                  full_i,
  output kslpd_pkg::job_t       job_o
);

  logic [kslpd_pkg::CountW-1:0] count_q [kslpd_pkg::KeySlots];
  logic [kslpd_pkg::CountW-1:0] count_d;
  logic [kslpd_pkg::KeySlots-1:0] held_q;
  logic held_mid, held_d, active, accept, released, pressed;
  logic [kslpd_pkg::CountW-1:0] cur;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign released   = key_state_i == kslpd_pkg::StReleased;
  assign pressed    = key_state_i == kslpd_pkg::StPressed;
  assign active     = (32'(key_index_i) < kslpd_pkg::NumKeys) && cfg_i.key_enable[key_index_i];
  assign cur        = count_q[key_index_i];

  always_comb begin
    held_mid = released ? 1'b0 : held_q[key_index_i];
    count_d  = cur;
    if (released) begin
      count_d = '0;
    end else if (pressed && !held_q[key_index_i] && cur != kslpd_pkg::CountMax) begin
      count_d = cur + 1'b1;
    end
    held_d = held_mid || (32'(count_d) >= kslpd_pkg::MaxHoldCount);
  end

  always_comb begin
    job_o.key      = key_index_i;
    job_o.gate     = active && !held_mid;
    job_o.count    = count_d;
    job_o.short_th = cfg_i.short_tbl[key_index_i*kslpd_pkg::CountW +: kslpd_pkg::CountW];
    job_o.long_th  = cfg_i.long_tbl[key_index_i*kslpd_pkg::CountW +: kslpd_pkg::CountW];
  end
  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < kslpd_pkg::KeySlots; k++) begin
        count_q[k] <= '0;
      end
      held_q <= '0;
    end else begin
      for (int k = 0; k < kslpd_pkg::KeySlots; k++) begin
        // enable toggles start the key clean
        if (cfg_i.clear_mask[k]) begin
          count_q[k] <= '0;
          held_q[k]  <= 1'b0;
        end else if (accept && active && 32'(key_index_i) == k) begin
          count_q[k] <= count_d;
          held_q[k]  <= held_d;
        end
      end
    end
  end

endmodule

[src/kslpd_fifo.sv]
// short job queue between front and back
// depends on kslpd_pkg
`timescale 1ns / 1ps

module kslpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kslpd_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output kslpd_pkg::job_t pop_data_o
);

  kslpd_pkg::job_t                mem_q [kslpd_pkg::FifoDepth];
  logic [kslpd_pkg::FifoPtrW-1:0] wr_q, rd_q;
  logic [kslpd_pkg::FifoCntW-1:0] cnt_q;

  assign full_o     = 32'(cnt_q) == kslpd_pkg::FifoDepth;
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == kslpd_pkg::FifoDepth - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == kslpd_pkg::FifoDepth - 1) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {{(kslpd_pkg::FifoCntW-1){1'b0}}, push_i}
                     - {{(kslpd_pkg::FifoCntW-1){1'b0}}, pop_i};
    end
  end

endmodule

[src/kslpd_back.sv]
// back part: short compare and bit-serial modulo for long repeats, result register
// depends on kslpd_pkg and the defines header
`timescale 1ns / 1ps
`include "key_short_long_press_detector_unit_defines.svh"

module kslpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  kslpd_pkg::job_t job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [kslpd_pkg::KeyW-1:0]   key_index_o,
  output logic [kslpd_pkg::EventW-1:0] press_event_o
);

  kslpd_pkg::back_state_e state_q, state_d;
  kslpd_pkg::press_event_e ev_q, ev_d;
  logic [kslpd_pkg::KeyW-1:0]    key_q;
  logic [kslpd_pkg::CountW-1:0]  quo_q, lth_q, rem_q, rem_d;
  logic [kslpd_pkg::DivCntW-1:0] bit_q;
  logic [kslpd_pkg::CountW:0]    trial;
  logic load;

  // one restoring division step per cycle
  always_comb begin
    trial = {rem_q, quo_q[kslpd_pkg::CountW-1]};
    rem_d = (trial >= {1'b0, lth_q}) ? kslpd_pkg::CountW'(trial - {1'b0, lth_q})
                                     : trial[kslpd_pkg::CountW-1:0];
  end

  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    load    = 1'b0;
    unique case (state_q)
      kslpd_pkg::BkIdle: begin
        if (job_valid_i) begin
          load    = 1'b1;
          state_d = kslpd_pkg::BkOut;
          if (!job_i.gate) begin
            ev_d = kslpd_pkg::EvNone;
          end else if (job_i.count == job_i.short_th) begin
            ev_d = kslpd_pkg::EvShort;
          end else if (job_i.long_th == '0 || job_i.count < job_i.long_th) begin
            ev_d = kslpd_pkg::EvNone;
          end else begin
            ev_d    = kslpd_pkg::EvNone;
            state_d = kslpd_pkg::BkDiv;
          end
        end
      end
      kslpd_pkg::BkDiv: begin
        if (bit_q == '0) begin
          ev_d    = (rem_d == '0) ? kslpd_pkg::EvLong : kslpd_pkg::EvNone;
          state_d = kslpd_pkg::BkOut;
        end
      end
      kslpd_pkg::BkOut: begin
        if (out_ready_i) begin
          state_d = kslpd_pkg::BkIdle;
        end
      end
      default: state_d = kslpd_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kslpd_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    if (load) begin
      key_q <= job_i.key;
      quo_q <= job_i.count;
      lth_q <= job_i.long_th;
      rem_q <= '0;
      bit_q <= kslpd_pkg::DivCntW'(kslpd_pkg::CountW - 1);
    end else if (state_q == kslpd_pkg::BkDiv) begin
      quo_q <= {quo_q[kslpd_pkg::CountW-2:0], 1'b0};
      rem_q <= rem_d;
      bit_q <= bit_q - 1'b1;
    end
  end

  assign pop_o         = load;
  assign out_valid_o   = state_q == kslpd_pkg::BkOut;
  assign key_index_o   = key_q;
  assign press_event_o = ev_q;

  `KSLPD_ASSERT(a_div_nonzero, clk_i, rst_ni,
    (state_q != kslpd_pkg::BkDiv) || (lth_q != '0), "modulo running with zero period")
  `KSLPD_ASSERT_NEXT(a_div_ends, clk_i, rst_ni,
    (state_q == kslpd_pkg::BkDiv) && (bit_q == '0), state_q == kslpd_pkg::BkOut,
    "modulo did not finish on last bit")
  `KSLPD_ASSERT(a_no_pop_busy, clk_i, rst_ni,
    !pop_o || (state_q == kslpd_pkg::BkIdle), "job taken while back part busy")
  `KSLPD_ASSERT_NEXT(a_out_holds, clk_i, rst_ni,
    out_valid_o && !out_ready_i, out_valid_o && $stable(ev_q) && $stable(key_q),
    "pending result changed")

endmodule
